// ===== rtl/core/ps2mt_pkg.sv =====
`timescale 1ns / 1ps

package ps2mt_pkg;

    // Sizes
    localparam int COORD_BITS   = 12;
    localparam int COUNTER_BITS = 16;
    localparam int POS_W        = 14;
    localparam int WHEEL_W      = 4;
    localparam int WSUM_W       = 16;
    localparam int BTN_W        = 3;
    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = COORD_BITS;
    localparam int DELTA_W      = COORD_BITS + 1;
    // signed work width for cursor sums and requested positions
    localparam int CW = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;

    // Stream word layout
    localparam int IN_BITS     = 8 + 2 * POS_W + BTN_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * COORD_BITS + 2 * DELTA_W + WHEEL_W + WSUM_W + BTN_W + 1
                                 + 2 * COUNTER_BITS;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_RX_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_POS  = 2'd1;
    localparam logic [OP_W-1:0] OP_ABS_POS  = 2'd2;
    localparam logic [OP_W-1:0] OP_SNAPSHOT = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW    = 2'd2;

    // Default bounds while a bound register is zero
    localparam logic [COORD_BITS-1:0] COL_FALLBACK = COORD_BITS'(1023);
    localparam logic [COORD_BITS-1:0] ROW_FALLBACK = COORD_BITS'(767);

    // Status byte bits, plus the wheel byte mask
    localparam logic [7:0] SYNC_MASK  = 8'h08;
    localparam logic [7:0] OVF_MASK   = 8'hC0;
    localparam logic [7:0] XSIGN_MASK = 8'h10;
    localparam logic [7:0] YSIGN_MASK = 8'h20;
    localparam logic [7:0] BTN_MASK   = 8'h07;
    localparam logic [7:0] WHEEL_MASK = 8'h0F;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [7:0]              rx_byte;
        logic signed [POS_W-1:0] pos_col;
        logic signed [POS_W-1:0] pos_row;
        logic [BTN_W-1:0]        abs_buttons;
    } t_item;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic [COORD_BITS-1:0]     cursor_col;
        logic [COORD_BITS-1:0]     cursor_row;
        logic signed [DELTA_W-1:0] delta_col;
        logic signed [DELTA_W-1:0] delta_row;
        logic signed [WHEEL_W-1:0] wheel_step;
        logic signed [WSUM_W-1:0]  wheel_total;
        logic [BTN_W-1:0]          button_bits;
        logic                      packet_done;
        logic                      dropped;
        logic                      absolute_flag;
        logic [COUNTER_BITS-1:0]   good_packets;
        logic [COUNTER_BITS-1:0]   desync_total;
    } t_result;

    // Clamp a signed coordinate to [0, bound], bound zero meaning fallback
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [CW-1:0]   v,
        input logic [COORD_BITS-1:0]  bound,
        input logic [COORD_BITS-1:0]  fallback
    );
        logic [COORD_BITS-1:0] hi;
        hi = (bound == '0) ? fallback : bound;
        if (v < 0) begin
            clamp_coord = '0;
        end else if (v > $signed({{(CW-COORD_BITS){1'b0}}, hi})) begin
            clamp_coord = hi;
        end else begin
            clamp_coord = v[COORD_BITS-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/ps2mt_in_reg.sv =====
`timescale 1ns / 1ps

module ps2mt_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [ps2mt_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [ps2mt_pkg::OP_W-1:0]    i_s_tuser,
    input  logic                          i_take,
    output logic                          o_valid,
    output ps2mt_pkg::t_item              o_item
);
    import ps2mt_pkg::*;

    localparam int COL_LO = 8;
    localparam int ROW_LO = COL_LO + POS_W;
    localparam int BTN_LO = ROW_LO + POS_W;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Unpack the incoming word
    always_comb begin
        n_item.opcode      = i_s_tuser;
        n_item.rx_byte     = i_s_tdata[7:0];
        n_item.pos_col     = i_s_tdata[COL_LO +: POS_W];
        n_item.pos_row     = i_s_tdata[ROW_LO +: POS_W];
        n_item.abs_buttons = i_s_tdata[BTN_LO +: BTN_W];
    end

    // Free or draining this cycle
    assign o_s_tready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/core/ps2mt_core.sv =====
`timescale 1ns / 1ps

module ps2mt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ps2mt_pkg::t_cfg_wr  i_cfg,
    input  logic                i_valid,
    input  ps2mt_pkg::t_item    i_item,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output ps2mt_pkg::t_result  o_res
);
    import ps2mt_pkg::*;

    // Packet assembly
    logic [1:0] r_byte_index, n_byte_index;
    logic [7:0] r_pb0, r_pb1, r_pb2;
    logic [7:0] n_pb0, n_pb1, n_pb2;

    // Tracker state
    logic [COORD_BITS-1:0]     r_col, n_col, r_row, n_row;
    logic signed [DELTA_W-1:0] r_dcol, n_dcol, r_drow, n_drow;
    logic signed [WHEEL_W-1:0] r_wheel, n_wheel;
    logic signed [WSUM_W-1:0]  r_wsum, n_wsum;
    logic [BTN_W-1:0]          r_btn, n_btn;
    logic                      r_abs, n_abs;
    logic [COUNTER_BITS-1:0]   r_good, n_good, r_drop, n_drop;

    // Configuration
    logic                  r_wheel_mode;
    logic [COORD_BITS-1:0] r_max_col, r_max_row;

    logic    r_out_valid;
    t_result r_out, n_res;
    logic    load;

    // Per-item scratch
    logic [7:0]                st;
    logic [7:0]                byte2;
    logic                      complete;
    logic [8:0]                dx9, dy9;
    logic signed [9:0]         dy10;
    logic signed [WHEEL_W-1:0] w4;
    logic signed [CW-1:0]      col_sum, row_sum, req_col, req_row;
    logic                      done, drop;

    assign o_take  = !r_out_valid || i_ready;
    assign load    = i_valid && o_take;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Next state for one item
    always_comb begin
        n_byte_index = r_byte_index;
        n_pb0   = r_pb0;
        n_pb1   = r_pb1;
        n_pb2   = r_pb2;
        n_col   = r_col;
        n_row   = r_row;
        n_dcol  = r_dcol;
        n_drow  = r_drow;
        n_wheel = r_wheel;
        n_wsum  = r_wsum;
        n_btn   = r_btn;
        n_abs   = r_abs;
        n_good  = r_good;
        n_drop  = r_drop;
        done    = 1'b0;
        drop    = 1'b0;

        // third packet byte may be the one arriving now
        st       = r_pb0;
        byte2    = (r_byte_index == 2'd2) ? i_item.rx_byte : r_pb2;
        complete = r_byte_index >= (r_wheel_mode ? 2'd3 : 2'd2);
        dx9      = {((st & XSIGN_MASK) != 8'h00), r_pb1};
        dy9      = {((st & YSIGN_MASK) != 8'h00), byte2};
        dy10     = -$signed({dy9[8], dy9});
        w4       = r_wheel_mode ? WHEEL_W'(i_item.rx_byte & WHEEL_MASK) : '0;
        col_sum  = $signed({{(CW-COORD_BITS){1'b0}}, r_col})
                   + $signed({{(CW-9){dx9[8]}}, dx9});
        row_sum  = $signed({{(CW-COORD_BITS){1'b0}}, r_row})
                   + $signed({{(CW-10){dy10[9]}}, dy10});
        req_col  = $signed({{(CW-POS_W){i_item.pos_col[POS_W-1]}}, i_item.pos_col});
        req_row  = $signed({{(CW-POS_W){i_item.pos_row[POS_W-1]}}, i_item.pos_row});

        case (i_item.opcode)
            OP_RX_BYTE: begin
                if (r_byte_index == 2'd0 && (i_item.rx_byte & SYNC_MASK) == 8'h00) begin
                    // out of sync: throw the byte away
                    drop = 1'b1;
                end else begin
                    case (r_byte_index)
                        2'd0:    n_pb0 = i_item.rx_byte;
                        2'd1:    n_pb1 = i_item.rx_byte;
                        2'd2:    n_pb2 = i_item.rx_byte;
                        default: ;
                    endcase
                    if (complete) begin
                        n_byte_index = 2'd0;
                        n_btn        = BTN_W'(st & BTN_MASK);
                        if ((st & OVF_MASK) != 8'h00) begin
                            // overflow: discard movement, keep buttons
                            drop    = 1'b1;
                            n_dcol  = '0;
                            n_drow  = '0;
                            n_wheel = '0;
                        end else begin
                            n_dcol  = {{(DELTA_W-9){dx9[8]}}, dx9};
                            n_drow  = {{(DELTA_W-10){dy10[9]}}, dy10};
                            n_wheel = w4;
                            n_wsum  = r_wsum + {{(WSUM_W-WHEEL_W){w4[WHEEL_W-1]}}, w4};
                            n_col   = clamp_coord(col_sum, r_max_col, COL_FALLBACK);
                            n_row   = clamp_coord(row_sum, r_max_row, ROW_FALLBACK);
                            n_good  = r_good + COUNTER_BITS'(1);
                            done    = 1'b1;
                        end
                    end else begin
                        n_byte_index = r_byte_index + 2'd1;
                    end
                end
                if (drop) begin
                    n_drop = r_drop + COUNTER_BITS'(1);
                end
            end
            OP_SET_POS: begin
                n_col   = clamp_coord(req_col, r_max_col, COL_FALLBACK);
                n_row   = clamp_coord(req_row, r_max_row, ROW_FALLBACK);
                n_dcol  = '0;
                n_drow  = '0;
                n_wheel = '0;
            end
            OP_ABS_POS: begin
                n_col   = clamp_coord(req_col, r_max_col, COL_FALLBACK);
                n_row   = clamp_coord(req_row, r_max_row, ROW_FALLBACK);
                n_dcol  = $signed({1'b0, n_col}) - $signed({1'b0, r_col});
                n_drow  = $signed({1'b0, n_row}) - $signed({1'b0, r_row});
                n_wheel = '0;
                n_btn   = i_item.abs_buttons;
                n_abs   = 1'b1;
                n_good  = r_good + COUNTER_BITS'(1);
                done    = 1'b1;
            end
            OP_SNAPSHOT: begin
                n_dcol  = '0;
                n_drow  = '0;
                n_wheel = '0;
            end
            default: ;
        endcase

        // Result word; a snapshot reports the deltas before clearing
        n_res.cursor_col    = n_col;
        n_res.cursor_row    = n_row;
        n_res.delta_col     = (i_item.opcode == OP_SNAPSHOT) ? r_dcol : n_dcol;
        n_res.delta_row     = (i_item.opcode == OP_SNAPSHOT) ? r_drow : n_drow;
        n_res.wheel_step    = (i_item.opcode == OP_SNAPSHOT) ? r_wheel : n_wheel;
        n_res.wheel_total   = n_wsum;
        n_res.button_bits   = n_btn;
        n_res.packet_done   = done;
        n_res.dropped       = drop;
        n_res.absolute_flag = n_abs;
        n_res.good_packets  = n_good;
        n_res.desync_total  = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= 2'd0;
            r_col        <= '0;
            r_row        <= '0;
            r_dcol       <= '0;
            r_drow       <= '0;
            r_wheel      <= '0;
            r_wsum       <= '0;
            r_btn        <= '0;
            r_abs        <= 1'b0;
            r_good       <= '0;
            r_drop       <= '0;
            r_wheel_mode <= 1'b0;
            r_max_col    <= '0;
            r_max_row    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_byte_index <= n_byte_index;
                r_col        <= n_col;
                r_row        <= n_row;
                r_dcol       <= n_dcol;
                r_drow       <= n_drow;
                r_wheel      <= n_wheel;
                r_wsum       <= n_wsum;
                r_btn        <= n_btn;
                r_abs        <= n_abs;
                r_good       <= n_good;
                r_drop       <= n_drop;
            end else if (i_cfg.we) begin
                // bound writes re-clamp the cursor right away
                case (i_cfg.idx)
                    CFG_WHEEL_MODE: r_wheel_mode <= i_cfg.data[0];
                    CFG_MAX_COL: begin
                        r_max_col <= i_cfg.data;
                        r_col     <= clamp_coord($signed({{(CW-COORD_BITS){1'b0}}, r_col}),
                                                 i_cfg.data, COL_FALLBACK);
                    end
                    CFG_MAX_ROW: begin
                        r_max_row <= i_cfg.data;
                        r_row     <= clamp_coord($signed({{(CW-COORD_BITS){1'b0}}, r_row}),
                                                 i_cfg.data, ROW_FALLBACK);
                    end
                    default: ;
                endcase
            end

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Packet bytes and result payload carry no reset
        if (load) begin
            r_pb0 <= n_pb0;
            r_pb1 <= n_pb1;
            r_pb2 <= n_pb2;
            r_out <= n_res;
        end
    end

endmodule

// ===== rtl/core/ps2_mouse_packet_cursor_tracker_top.sv =====
// Path: a word accepted at the input passes the input register, then the result
//   register after one pass of update logic.
// Throughput: one word per cycle. While a result waits the block holds at most
//   two words, one in each register, and then drops o_s_tready.
// Reset: i_rst_n is synchronous, active low; it clears cursor, deltas, counters,
//   configuration and both valid flags. The packet byte store is not reset.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: rx_byte[7:0], pos_col[21:8], pos_row[35:22], abs_buttons[38:36], zero fill
    input  logic [ps2mt_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [ps2mt_pkg::OP_W-1:0]         i_s_tuser,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: cursor_col[11:0], cursor_row[23:12], delta_col[36:24], delta_row[49:37],
    //        wheel_step[53:50], wheel_total[69:54], button_bits[72:70],
    //        absolute_flag[73], good_packets[89:74], desync_total[105:90], zero fill
    output logic [ps2mt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // tuser: packet_done[0], dropped[1]
    output logic [ps2mt_pkg::OUT_USER_W-1:0]   o_m_tuser,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [ps2mt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ps2mt_pkg::CFG_W-1:0]        i_cfg_data
);
    import ps2mt_pkg::*;

    logic    in_valid;
    logic    take;
    t_item   item;
    t_cfg_wr cfg;
    t_result res;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    ps2mt_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (take),
        .o_valid    (in_valid),
        .o_item     (item)
    );

    ps2mt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (in_valid),
        .i_item  (item),
        .o_take  (take),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    // Pack the result word, first field lowest
    assign o_m_tdata = OUT_DATA_W'({res.desync_total, res.good_packets, res.absolute_flag,
                                    res.button_bits, res.wheel_total, res.wheel_step,
                                    res.delta_row, res.delta_col,
                                    res.cursor_row, res.cursor_col});
    assign o_m_tuser = {res.dropped, res.packet_done};

endmodule

// ===== rtl/core/ps2mt_checker.sv =====
`timescale 1ns / 1ps

module ps2mt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [ps2mt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input logic [ps2mt_pkg::OUT_USER_W-1:0]   o_m_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // A word cannot both complete a packet and count a drop
    a_done_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("packet_done and dropped both set");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Input only stalls behind a stalled result word
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled while output free");

endmodule

bind ps2_mouse_packet_cursor_tracker_top ps2mt_checker u_ps2mt_checker (.*);

// ===== tb/tb_ps2_mouse_packet_cursor_tracker_top.sv =====
`timescale 1ns / 1ps

// Cursor tracker model plus the queue of words it predicts
class cursor_scoreboard;

    // configuration copy
    bit                 cfg_wheel;
    logic [11:0]        cfg_max_col;
    logic [11:0]        cfg_max_row;

    // tracker state
    int                 idx;
    logic [7:0]         pkt_store [3];
    logic [11:0]        cur_col;
    logic [11:0]        cur_row;
    int                 mv_col;
    int                 mv_row;
    int                 mv_wheel;
    logic [15:0]        wheel_acc;
    logic [2:0]         btns;
    bit                 abs_seen;
    logic [15:0]        good_cnt;
    logic [15:0]        drop_cnt;

    ps2mt_pkg::t_result expected_q [$];

    // run statistics
    int errors;
    int words_in;
    int words_out;
    int packets;
    int drops;
    int abs_updates;

    function new();
        cfg_wheel   = 0;
        cfg_max_col = '0;
        cfg_max_row = '0;
        idx         = 0;
        cur_col     = '0;
        cur_row     = '0;
        mv_col      = 0;
        mv_row      = 0;
        mv_wheel    = 0;
        wheel_acc   = '0;
        btns        = '0;
        abs_seen    = 0;
        good_cnt    = '0;
        drop_cnt    = '0;
        errors      = 0;
        words_in    = 0;
        words_out   = 0;
        packets     = 0;
        drops       = 0;
        abs_updates = 0;
    endfunction

    // clamp to [0, bound], zero bound meaning the fallback
    function logic [11:0] fit_axis(int v, logic [11:0] bound, logic [11:0] fallback);
        int hi;
        hi = (bound == '0) ? int'(fallback) : int'(bound);
        if (v < 0) return '0;
        if (v > hi) return 12'(hi);
        return 12'(v);
    endfunction

    function void write_reg(logic [1:0] ridx, logic [11:0] val);
        case (ridx)
            ps2mt_pkg::CFG_WHEEL_MODE: cfg_wheel = val[0];
            ps2mt_pkg::CFG_MAX_COL:    cfg_max_col = val;
            ps2mt_pkg::CFG_MAX_ROW:    cfg_max_row = val;
            default: ;
        endcase
        // a new bound pulls the cursor in right away
        if (ridx != ps2mt_pkg::CFG_WHEEL_MODE) begin
            cur_col = fit_axis(int'(cur_col), cfg_max_col, ps2mt_pkg::COL_FALLBACK);
            cur_row = fit_axis(int'(cur_row), cfg_max_row, ps2mt_pkg::ROW_FALLBACK);
        end
    endfunction

    // predict the word caused by one accepted input word
    function void note_word(ps2mt_pkg::t_item w);
        ps2mt_pkg::t_result r;
        logic [7:0]  st;
        logic [11:0] prev_col;
        logic [11:0] prev_row;
        int          len;
        int          dx;
        int          dy;
        int          wstep;
        int          snap_col;
        int          snap_row;
        int          snap_wheel;
        bit          fin;
        bit          dropped_now;

        fin         = 0;
        dropped_now = 0;
        words_in++;
        case (w.opcode)
            ps2mt_pkg::OP_RX_BYTE: begin
                if (idx == 0 && (w.rx_byte & ps2mt_pkg::SYNC_MASK) == 0) begin
                    // out of sync: first byte lacks the always-one bit
                    dropped_now = 1;
                end else begin
                    len = cfg_wheel ? 4 : 3;
                    if (idx < 3) pkt_store[idx] = w.rx_byte;
                    if (idx + 1 >= len) begin
                        st  = pkt_store[0];
                        idx = 0;
                        if ((st & ps2mt_pkg::OVF_MASK) != 0) begin
                            // overflow: movement discarded, buttons kept
                            dropped_now = 1;
                            mv_col      = 0;
                            mv_row      = 0;
                            mv_wheel    = 0;
                            btns        = 3'(st & ps2mt_pkg::BTN_MASK);
                        end else begin
                            dx    = int'(pkt_store[1]);
                            dy    = int'(pkt_store[2]);
                            wstep = 0;
                            if (len == 4) begin
                                wstep = w.rx_byte[3] ? int'(w.rx_byte[3:0]) - 16
                                                     : int'(w.rx_byte[3:0]);
                            end
                            if ((st & ps2mt_pkg::XSIGN_MASK) != 0) dx -= 256;
                            if ((st & ps2mt_pkg::YSIGN_MASK) != 0) dy -= 256;
                            dy        = -dy;
                            mv_col    = dx;
                            mv_row    = dy;
                            mv_wheel  = wstep;
                            wheel_acc = wheel_acc + 16'(wstep);
                            btns      = 3'(st & ps2mt_pkg::BTN_MASK);
                            cur_col   = fit_axis(int'(cur_col) + dx, cfg_max_col,
                                                 ps2mt_pkg::COL_FALLBACK);
                            cur_row   = fit_axis(int'(cur_row) + dy, cfg_max_row,
                                                 ps2mt_pkg::ROW_FALLBACK);
                            good_cnt  = good_cnt + 16'd1;
                            fin       = 1;
                            packets++;
                        end
                    end else begin
                        idx = idx + 1;
                    end
                end
                if (dropped_now) begin
                    drop_cnt = drop_cnt + 16'd1;
                    drops++;
                end
            end
            ps2mt_pkg::OP_SET_POS: begin
                cur_col  = fit_axis(int'(w.pos_col), cfg_max_col, ps2mt_pkg::COL_FALLBACK);
                cur_row  = fit_axis(int'(w.pos_row), cfg_max_row, ps2mt_pkg::ROW_FALLBACK);
                mv_col   = 0;
                mv_row   = 0;
                mv_wheel = 0;
            end
            ps2mt_pkg::OP_ABS_POS: begin
                prev_col = cur_col;
                prev_row = cur_row;
                cur_col  = fit_axis(int'(w.pos_col), cfg_max_col, ps2mt_pkg::COL_FALLBACK);
                cur_row  = fit_axis(int'(w.pos_row), cfg_max_row, ps2mt_pkg::ROW_FALLBACK);
                mv_col   = int'(cur_col) - int'(prev_col);
                mv_row   = int'(cur_row) - int'(prev_row);
                mv_wheel = 0;
                btns     = w.abs_buttons;
                abs_seen = 1;
                good_cnt = good_cnt + 16'd1;
                fin      = 1;
                abs_updates++;
            end
            default: ;
        endcase

        // snapshot reports the deltas, then clears them
        snap_col   = mv_col;
        snap_row   = mv_row;
        snap_wheel = mv_wheel;
        if (w.opcode == ps2mt_pkg::OP_SNAPSHOT) begin
            mv_col   = 0;
            mv_row   = 0;
            mv_wheel = 0;
        end

        r.cursor_col    = cur_col;
        r.cursor_row    = cur_row;
        r.delta_col     = 13'(snap_col);
        r.delta_row     = 13'(snap_row);
        r.wheel_step    = 4'(snap_wheel);
        r.wheel_total   = wheel_acc;
        r.button_bits   = btns;
        r.packet_done   = fin;
        r.dropped       = dropped_now;
        r.absolute_flag = abs_seen;
        r.good_packets  = good_cnt;
        r.desync_total  = drop_cnt;
        expected_q.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task cmp_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
        if (got_v !== exp_v) begin
            report($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                             words_out, name, got_v, exp_v));
        end
    endtask

    // compare one output word against the oldest prediction
    task check_word(logic [ps2mt_pkg::OUT_DATA_W-1:0] d,
                    logic [ps2mt_pkg::OUT_USER_W-1:0] u);
        ps2mt_pkg::t_result e;
        words_out++;
        if (expected_q.size() == 0) begin
            report($sformatf("word %0d arrived with nothing expected", words_out));
            return;
        end
        e = expected_q.pop_front();
        cmp_field("cursor_col",    32'(d[11:0]),   32'(e.cursor_col));
        cmp_field("cursor_row",    32'(d[23:12]),  32'(e.cursor_row));
        cmp_field("delta_col",     32'(d[36:24]),  32'({e.delta_col}));
        cmp_field("delta_row",     32'(d[49:37]),  32'({e.delta_row}));
        cmp_field("wheel_step",    32'(d[53:50]),  32'({e.wheel_step}));
        cmp_field("wheel_total",   32'(d[69:54]),  32'({e.wheel_total}));
        cmp_field("button_bits",   32'(d[72:70]),  32'(e.button_bits));
        cmp_field("absolute_flag", 32'(d[73]),     32'(e.absolute_flag));
        cmp_field("good_packets",  32'(d[89:74]),  32'(e.good_packets));
        cmp_field("desync_total",  32'(d[105:90]), 32'(e.desync_total));
        cmp_field("packet_done",   32'(u[0]),      32'(e.packet_done));
        cmp_field("dropped",       32'(u[1]),      32'(e.dropped));
    endtask

endclass

module tb_ps2_mouse_packet_cursor_tracker_top;

    import ps2mt_pkg::*;

    localparam int SINK_HOLD = 80;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [OP_W-1:0]       i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;

    cursor_scoreboard sb;
    t_item            seen_word;
    bit               no_gaps;
    bit               hold_sink;
    int               n_cfg;

    ps2_mouse_packet_cursor_tracker_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb_ps2_mouse_packet_cursor_tracker_top: errors");
        $finish;
    end

    // handshake monitor: results are checked, accepted words predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_word(o_m_tdata, o_m_tuser);
            if (i_s_tvalid && o_s_tready) begin
                seen_word.opcode      = i_s_tuser;
                seen_word.rx_byte     = i_s_tdata[7:0];
                seen_word.pos_col     = i_s_tdata[21:8];
                seen_word.pos_row     = i_s_tdata[35:22];
                seen_word.abs_buttons = i_s_tdata[38:36];
                sb.note_word(seen_word);
            end
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin : sink
        int stall_left;
        bit rdy;
        i_m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready = 1'b0;
                repeat (SINK_HOLD) @(negedge i_clk);
                hold_sink = 0;
            end
            if (stall_left > 0) begin
                rdy = 0;
                stall_left--;
            end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
                rdy = 0;
                stall_left = $urandom_range(0, 9);
            end else begin
                rdy = 1;
            end
            i_m_tready = rdy;
        end
    end

    function automatic t_item any_word(logic [OP_W-1:0] op);
        t_item w;
        w.opcode      = op;
        w.rx_byte     = 8'($urandom);
        w.pos_col     = 14'($urandom);
        w.pos_row     = 14'($urandom);
        w.abs_buttons = 3'($urandom);
        return w;
    endfunction

    function automatic int pick_bound();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4095;
            2:       return $urandom_range(1, 15);
            default: return $urandom_range(16, 4094);
        endcase
    endfunction

    // offer one word, with an occasional gap before it; ends on a falling edge
    task automatic send_word(t_item w);
        if (!no_gaps && $urandom_range(0, 4) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = IN_DATA_W'({w.abs_buttons, w.pos_row, w.pos_col, w.rx_byte});
        i_s_tuser  = w.opcode;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_rx(logic [7:0] b);
        t_item w;
        w         = any_word(OP_RX_BYTE);
        w.rx_byte = b;
        send_word(w);
    endtask

    task automatic send_cmd(logic [OP_W-1:0] op, int pc, int pr, logic [2:0] ab);
        t_item w;
        w             = any_word(op);
        w.pos_col     = 14'(pc);
        w.pos_row     = 14'(pr);
        w.abs_buttons = ab;
        send_word(w);
    endtask

    // set/abs/snapshot with positions either anywhere or near the bounds
    task automatic send_cmd_random();
        t_item w;
        w = any_word(OP_W'($urandom_range(OP_SET_POS, OP_SNAPSHOT)));
        if ($urandom_range(0, 1) == 1) begin
            w.pos_col = 14'(int'($urandom_range(0, 1100)) - 30);
            w.pos_row = 14'(int'($urandom_range(0, 820)) - 30);
        end
        send_word(w);
    endtask

    // stop offering and wait for every predicted word to come out
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] ridx, int val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = ridx;
        i_cfg_data = CFG_W'(val);
        sb.write_reg(ridx, 12'(val));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        @(negedge i_clk);
        n_cfg++;
    endtask

    // mostly well-formed packets with random content, some noise and commands
    task automatic run_phase(int n_words);
        int         sent;
        int         pick;
        int         k;
        int         len;
        logic [7:0] st;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                st = {2'b00, 2'($urandom), 1'b1, 3'($urandom)};
                if ($urandom_range(0, 7) == 0) st[7:6] = 2'($urandom_range(1, 3));
                send_rx(st);
                sent++;
                len = sb.cfg_wheel ? 4 : 3;
                for (k = 1; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_cmd_random();
                        sent++;
                    end
                    send_rx(8'($urandom));
                    sent++;
                end
            end else if (pick < 80) begin
                send_rx(8'($urandom));
                sent++;
            end else begin
                send_cmd_random();
                sent++;
            end
        end
    endtask

    initial begin : main
        int ph;
        int guard;
        sb         = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_RX_BYTE;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_WHEEL_MODE;
        i_cfg_data = '0;
        no_gaps    = 0;
        hold_sink  = 0;
        n_cfg      = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: three-byte mode, fallback bounds
        send_rx(8'h00);                       // no sync bit
        send_rx(8'hF7);                       // no sync bit, high bits set
        send_rx(8'h08); send_rx(8'h7F); send_rx(8'h80);
        send_rx(8'h3F); send_rx(8'h00); send_rx(8'hFF);  // both signs, all buttons
        send_rx(8'hCD); send_rx(8'hFF); send_rx(8'hFF);  // overflow
        send_cmd(OP_SNAPSHOT, 0, 0, 3'd0);
        send_cmd(OP_SNAPSHOT, 0, 0, 3'd0);
        send_cmd(OP_SET_POS, 8191, -8192, 3'd0);
        send_cmd(OP_ABS_POS, -8192, 8191, 3'd7);
        send_cmd(OP_ABS_POS, 500, 300, 3'd0);
        settle();

        // wheel packets, a command inside a packet, then mode switch mid-packet
        cfg_write(CFG_WHEEL_MODE, 1);
        send_rx(8'h09); send_rx(8'h05); send_rx(8'hFB); send_rx(8'h08);
        send_rx(8'h0A); send_rx(8'h01);
        send_cmd(OP_SET_POS, 12, 34, 3'd0);
        send_rx(8'h02); send_rx(8'hF7);
        send_rx(8'h08); send_rx(8'h01); send_rx(8'h01);
        settle();
        cfg_write(CFG_WHEEL_MODE, 0);
        send_rx(8'h0F);
        settle();

        // widest bounds, then a bound write that pulls the cursor in
        cfg_write(CFG_MAX_COL, 4095);
        cfg_write(CFG_MAX_ROW, 4095);
        send_cmd(OP_SET_POS, 8191, 8191, 3'd0);
        settle();
        cfg_write(CFG_MAX_COL, 1);
        cfg_write(CFG_MAX_ROW, 0);
        send_cmd(OP_SNAPSHOT, 0, 0, 3'd0);

        // random phases, each under fresh settings
        for (ph = 0; ph < 8; ph++) begin
            settle();
            cfg_write(CFG_WHEEL_MODE, $urandom_range(0, 1));
            cfg_write(CFG_MAX_COL, pick_bound());
            cfg_write(CFG_MAX_ROW, pick_bound());
            no_gaps = (ph == 4 || ph == 7);
            if (ph == 2) hold_sink = 1;
            run_phase(45);
        end

        // drain, bounded
        i_s_tvalid = 1'b0;
        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 2000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.report($sformatf("%0d expected words never came out", sb.expected_q.size()));
        end

        $display("covered %0d input words, %0d results: %0d packets, %0d drops, %0d abs updates",
                 sb.words_in, sb.words_out, sb.packets, sb.drops, sb.abs_updates);
        $display("%0d register writes over mode and bound settings incl. zero and 4095",
                 n_cfg);
        if (sb.errors == 0) begin
            $display("tb_ps2_mouse_packet_cursor_tracker_top: clean");
        end else begin
            $display("tb_ps2_mouse_packet_cursor_tracker_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ps2mt_pkg.sv
rtl/core/ps2mt_in_reg.sv
rtl/core/ps2mt_core.sv
rtl/core/ps2_mouse_packet_cursor_tracker_top.sv
rtl/core/ps2mt_checker.sv
tb/tb_ps2_mouse_packet_cursor_tracker_top.sv
